// ===== design/rdx50_pkg.sv =====
// ----------------------------------------------------------------------------
// rdx50_pkg
// Shared types and constants for the Radix-50 6.3 filename encoder.
// ----------------------------------------------------------------------------
package rdx50_pkg;

  localparam int CODE_W    = 6;
  localparam int WORD_W    = 16;
  localparam int COMP_D    = 9;
  localparam int NAME_N    = 6;
  localparam int EXT_N     = 3;
  localparam int RADIX     = 40;

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DOT   = 8'h2E;

  typedef logic [CODE_W-1:0] code_t;
  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    logic       go;
    logic       last;
    logic [7:0] ch;
  } step_t;

  typedef struct packed {
    code_t [NAME_N-1:0] name;
    code_t [EXT_N-1:0]  ext;
  } codes_t;

endpackage

// ===== design/rdx50_track.sv =====
// ----------------------------------------------------------------------------
// rdx50_track
// Path component tracker: maps bytes to codes, keeps the current component
// and its last extension, and selects the name and extension codes.
// ----------------------------------------------------------------------------
module rdx50_track (
  input  logic            clk,
  input  logic            rst_n,
  input  rdx50_pkg::step_t step,
  output rdx50_pkg::codes_t codes
);
  import rdx50_pkg::*;

  localparam code_t CODE_BLANK = 6'o00;
  localparam code_t CODE_PUNCT = 6'o33;
  localparam code_t CODE_DOT   = 6'o34;
  localparam code_t CODE_OTHER = 6'o35;
  localparam logic [6:0] LOW7  = 7'o177;

  function automatic code_t char_code(input logic [7:0] ch);
    logic [6:0] c;
    logic [6:0] d;
    c = ch[6:0] & LOW7;
    d = 7'd0;
    priority if (c >= 7'h61 && c <= 7'h7A) begin
      d = c - 7'h60;
    end else if (c >= 7'h30 && c <= 7'h39) begin
      d = c - 7'h30 + 7'd30;
    end else if (c == 7'h20 || c == 7'h09) begin
      d = {1'b0, CODE_BLANK};
    end else if (c >= 7'h41 && c <= 7'h5A) begin
      d = c - 7'h40;
    end else if (c == 7'h2D || c == 7'h5F || c == 7'h24) begin
      d = {1'b0, CODE_PUNCT};
    end else if (c == 7'h2E) begin
      d = {1'b0, CODE_DOT};
    end else begin
      d = {1'b0, CODE_OTHER};
    end
    return d[CODE_W-1:0];
  endfunction

  code_t [COMP_D-1:0] comp_r, comp_upd;
  logic [3:0]         len_r, len_upd;
  logic               dot_r, dot_upd;
  logic [2:0]         dpos_r, dpos_upd;
  code_t [EXT_N-1:0]  ext_r, ext_upd;
  logic [1:0]         elen_r, elen_upd;

  code_t              code;
  logic               active;
  logic               is_sep;
  logic [3:0]         limit;

  always_comb begin
    code     = char_code(step.ch);
    active   = step.go && (step.ch != 8'h00) && (step.ch != CH_SLASH);
    is_sep   = (step.ch == CH_DOT);
    comp_upd = comp_r;
    len_upd  = len_r;
    dot_upd  = dot_r;
    dpos_upd = dpos_r;
    ext_upd  = ext_r;
    elen_upd = elen_r;
    if (step.go && step.ch == CH_SLASH) begin
      comp_upd = '0;
      len_upd  = '0;
      dot_upd  = 1'b0;
      dpos_upd = '0;
      ext_upd  = '0;
      elen_upd = '0;
    end else if (active) begin
      if (is_sep) begin
        dot_upd  = 1'b1;
        dpos_upd = (len_r < 4'(NAME_N)) ? len_r[2:0] : 3'(NAME_N);
        ext_upd  = '0;
        elen_upd = '0;
      end else if (dot_r && elen_r < 2'(EXT_N)) begin
        for (int i = 0; i < EXT_N; i++) begin
          if (elen_r == 2'(i)) ext_upd[i] = code;
        end
        elen_upd = elen_r + 2'd1;
      end
      if (len_r < 4'(COMP_D)) begin
        for (int i = 0; i < COMP_D; i++) begin
          if (len_r == 4'(i)) comp_upd[i] = code;
        end
        len_upd = len_r + 4'd1;
      end
    end
  end

  always_comb begin
    limit = dot_upd ? {1'b0, dpos_upd} : len_upd;
    for (int i = 0; i < NAME_N; i++) begin
      codes.name[i] = (4'(i) < limit) ? comp_upd[i] : '0;
    end
    for (int i = 0; i < EXT_N; i++) begin
      if (dot_upd) begin
        codes.ext[i] = (2'(i) < elen_upd) ? ext_upd[i] : '0;
      end else begin
        codes.ext[i] = (4'(NAME_N + i) < len_upd) ? comp_upd[NAME_N + i] : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step.go && step.last)) begin
      comp_r <= '0;
      len_r  <= '0;
      dot_r  <= 1'b0;
      dpos_r <= '0;
      ext_r  <= '0;
      elen_r <= '0;
    end else begin
      comp_r <= comp_upd;
      len_r  <= len_upd;
      dot_r  <= dot_upd;
      dpos_r <= dpos_upd;
      ext_r  <= ext_upd;
      elen_r <= elen_upd;
    end
  end

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (step.go && step.last) |=> (len_r == 4'd0 && !dot_r && elen_r == 2'd0))
    else $error("component state not cleared after last byte");

endmodule

// ===== design/rdx50_pack.sv =====
// ----------------------------------------------------------------------------
// rdx50_pack
// Packs three codes into one base-40 word per group.
// ----------------------------------------------------------------------------
module rdx50_pack (
  input  rdx50_pkg::codes_t codes,
  output rdx50_pkg::word_t  name_high,
  output rdx50_pkg::word_t  name_low,
  output rdx50_pkg::word_t  extension_word
);
  import rdx50_pkg::*;

  function automatic word_t pack3(input code_t a, input code_t b, input code_t c);
    logic [17:0] s;
    s = 18'(a) * 18'(RADIX * RADIX) + 18'(b) * 18'(RADIX) + 18'(c);
    return s[WORD_W-1:0];
  endfunction

  assign name_high      = pack3(codes.name[0], codes.name[1], codes.name[2]);
  assign name_low       = pack3(codes.name[3], codes.name[4], codes.name[5]);
  assign extension_word = pack3(codes.ext[0], codes.ext[1], codes.ext[2]);

endmodule

// ===== design/radix50_filename_encoder.sv =====
// ----------------------------------------------------------------------------
// radix50_filename_encoder
// Path string to 6.3 Radix-50 filename words.
// ----------------------------------------------------------------------------
// Input channel: one path byte per request on in_tdata, in_tlast on the final
// byte. A slash starts a new component, a zero byte is ignored.
// Output channel: one request per path, issued for the byte marked tlast,
// carrying name_high, name_low and extension_word.
// Result: the last byte passes from the input register to the result register,
// which takes the packed words once it is free.
// Throughput: one byte per cycle; the component update and word packing
// sit between the input and result registers; a last byte can stall.
// Reset: clears all component state and both valid flags; no request is held.
// Stall: while a result waits, bytes that are not last keep flowing; a last
// byte holds in the input register until the result register frees up.
// ----------------------------------------------------------------------------
module radix50_filename_encoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] ch
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // [15:0] name_high, [31:16] name_low,
                                  // [47:32] extension_word
);
  import rdx50_pkg::*;

  logic       v_r;
  logic [7:0] ch_r;
  logic       last_r;
  logic       out_valid_r;
  word_t      nh_r, nl_r, ew_r;

  logic       out_free;
  logic       consume;
  step_t      step;
  codes_t     codes;
  word_t      nh, nl, ew;

  assign out_free  = !out_valid_r || out_tready;
  assign consume   = v_r && (!last_r || out_free);
  assign in_tready = !v_r || consume;

  assign step.go   = consume;
  assign step.last = last_r;
  assign step.ch   = ch_r;

  rdx50_track u_track (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .codes (codes)
  );

  rdx50_pack u_pack (
    .codes          (codes),
    .name_high      (nh),
    .name_low       (nl),
    .extension_word (ew)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_tready) begin
      v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      ch_r   <= in_tdata;
      last_r <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (consume && last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (consume && last_r) begin
      nh_r <= nh;
      nl_r <= nl;
      ew_r <= ew;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {ew_r, nl_r, nh_r};

  a_last_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r && last_r && !out_free) |=> (v_r && last_r && $stable(ch_r)))
    else $error("blocked last byte lost from input register");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(v_r && last_r))
    else $error("result issued without a last byte");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r && !last_r) |-> in_tready)
    else $error("input stalled behind a non-last byte");

endmodule

// ===== dv/radix50_filename_encoder_checker.sv =====
// ----------------------------------------------------------------------------
// radix50_filename_encoder_checker
// Predicts and checks the Radix-50 words of every path sent to the encoder.
// ----------------------------------------------------------------------------
// Watches the input and result channels. Each accepted byte updates a
// private copy of the component state. Each byte marked last queues the
// three words that the path must produce. Each accepted result is compared
// field by field with the oldest queued words. Hands the number of failures
// and the number of results still owed to the testbench top.
// ----------------------------------------------------------------------------
module radix50_filename_encoder_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] ch
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [47:0] out_tdata,  // [15:0] name_high, [31:16] name_low,
                                  // [47:32] extension_word
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import rdx50_pkg::*;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_TAB = 8'h09;

  localparam code_t CODE_BLANK  = 6'd0;
  localparam code_t CODE_PUNCT  = 6'd27;
  localparam code_t CODE_DOT    = 6'd28;
  localparam code_t CODE_OTHER  = 6'd29;
  localparam code_t CODE_DIGIT0 = 6'd30;

  typedef struct packed {
    word_t ext_word;
    word_t name_low;
    word_t name_high;
  } path_words_t;

  path_words_t expected_words[$];

  code_t comp_codes[COMP_D];
  int    comp_len;
  bit    dot_seen;
  int    dot_pos;
  code_t ext_codes[EXT_N];
  int    ext_len;
  int    mismatches = 0;

  function automatic code_t char_code(logic [7:0] b);
    logic [7:0] c;
    c = {1'b0, b[6:0]};
    if (c >= "a" && c <= "z") return code_t'(c - "a" + 8'd1);
    if (c >= "0" && c <= "9") return CODE_DIGIT0 + code_t'(c - "0");
    if (c == " " || c == CH_TAB) return CODE_BLANK;
    if (c >= "A" && c <= "Z") return code_t'(c - "A" + 8'd1);
    if (c == "-" || c == "_" || c == "$") return CODE_PUNCT;
    if (c == ".") return CODE_DOT;
    return CODE_OTHER;
  endfunction

  function automatic word_t pack_word(code_t a, code_t b, code_t c);
    return word_t'(int'(a) * RADIX * RADIX + int'(b) * RADIX + int'(c));
  endfunction

  task automatic clear_component();
    foreach (comp_codes[i]) comp_codes[i] = CODE_BLANK;
    foreach (ext_codes[i]) ext_codes[i] = CODE_BLANK;
    comp_len = 0;
    dot_seen = 1'b0;
    dot_pos  = 0;
    ext_len  = 0;
  endtask

  task automatic take_byte(logic [7:0] b, logic fin);
    code_t       code;
    code_t       name[NAME_N];
    code_t       ext[EXT_N];
    int          lim;
    path_words_t w;
    if (b == CH_SLASH) begin
      clear_component();
    end else if (b != CH_NUL) begin
      code = char_code(b);
      if (b == CH_DOT) begin
        dot_seen = 1'b1;
        dot_pos  = (comp_len < NAME_N) ? comp_len : NAME_N;
        foreach (ext_codes[i]) ext_codes[i] = CODE_BLANK;
        ext_len  = 0;
      end else if (dot_seen && ext_len < EXT_N) begin
        ext_codes[ext_len] = code;
        ext_len++;
      end
      if (comp_len < COMP_D) begin
        comp_codes[comp_len] = code;
        comp_len++;
      end
    end
    if (fin) begin
      lim = dot_seen ? dot_pos : comp_len;
      for (int i = 0; i < NAME_N; i++) begin
        name[i] = (i < lim) ? comp_codes[i] : CODE_BLANK;
      end
      for (int i = 0; i < EXT_N; i++) begin
        if (dot_seen) begin
          ext[i] = (i < ext_len) ? ext_codes[i] : CODE_BLANK;
        end else begin
          ext[i] = (NAME_N + i < comp_len) ? comp_codes[NAME_N + i] : CODE_BLANK;
        end
      end
      w.name_high = pack_word(name[0], name[1], name[2]);
      w.name_low  = pack_word(name[3], name[4], name[5]);
      w.ext_word  = pack_word(ext[0], ext[1], ext[2]);
      expected_words.push_back(w);
      clear_component();
    end
  endtask

  task automatic check_field(string field, word_t want, word_t got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    path_words_t want;
    path_words_t got;
    if (!rst_n) begin
      clear_component();
      expected_words.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (expected_words.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, actual %h", $time, got);
        end else begin
          want = expected_words.pop_front();
          check_field("name_high", want.name_high, got.name_high);
          check_field("name_low", want.name_low, got.name_low);
          check_field("extension_word", want.ext_word, got.ext_word);
        end
      end
      if (in_tvalid && in_tready) take_byte(in_tdata, in_tlast);
    end
    fail_count <= mismatches;
    pending    <= expected_words.size();
  end

endmodule

// ===== dv/radix50_filename_encoder_tb.sv =====
// ----------------------------------------------------------------------------
// radix50_filename_encoder_tb
// Stimulus and verdict for the Radix-50 6.3 filename encoder.
// ----------------------------------------------------------------------------
// Sends a few hand-picked paths (slashes, dots, saturation, high-bit bytes,
// zero bytes, empty names), then random paths that are mostly well formed
// with some raw byte noise. Both sides idle in random bursts; once the
// result side holds off for a long stretch so the encoder backs up; the
// sender drains every result midway and at the end. The checker beside the
// encoder predicts and compares; this module reports its failure count.
// ----------------------------------------------------------------------------
module radix50_filename_encoder_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rdx50_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int LONG_HOLD    = 200;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_BYTES = 1500;
  localparam int QUIET_BYTES  = 150;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;
  int          fail_count;
  int          pending;

  bit          idle_on  = 1'b1;
  bit          hold_req = 1'b0;
  int          bytes_sent = 0;
  logic [7:0]  path_q[$];

  radix50_filename_encoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  radix50_filename_encoder_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] pick_char();
    logic [7:0] v;
    case ($urandom_range(0, 15))
      0, 1, 2: v = 8'("a" + $urandom_range(0, 25));
      3:       v = 8'("A" + $urandom_range(0, 25));
      4, 5:    v = 8'("0" + $urandom_range(0, 9));
      6:       v = $urandom_range(0, 1) ? " " : 8'h09;
      7: begin
        case ($urandom_range(0, 2))
          0:       v = "-";
          1:       v = "_";
          default: v = "$";
        endcase
      end
      8:       v = 8'($urandom_range(8'h01, 8'h7F));
      9:       v = {1'b1, 7'($urandom_range(0, 127))};
      10:      v = 8'h00;
      11:      v = $urandom_range(0, 1) ? {1'b1, CH_DOT[6:0]} : {1'b1, CH_SLASH[6:0]};
      default: v = 8'("a" + $urandom_range(0, 25));
    endcase
    return v;
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) path_q.push_back(s[i]);
  endfunction

  task automatic send_byte(logic [7:0] b, logic fin);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 11) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = b;
    in_tlast  = fin;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (b != 8'h00) bytes_sent++;
  endtask

  task automatic send_path();
    for (int i = 0; i < path_q.size(); i++) send_byte(path_q[i], i == path_q.size() - 1);
    path_q.delete();
  endtask

  task automatic gen_path();
    int ncomp;
    int nlen;
    path_q.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 12)) path_q.push_back(8'($urandom));
    end else begin
      ncomp = $urandom_range(1, 3);
      for (int k = 0; k < ncomp; k++) begin
        if (k > 0 || $urandom_range(0, 7) == 0) path_q.push_back(CH_SLASH);
        nlen = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 14) : $urandom_range(0, 6);
        repeat (nlen) path_q.push_back(pick_char());
        if ($urandom_range(0, 3) != 0) begin
          repeat ($urandom_range(1, 2)) begin
            path_q.push_back(CH_DOT);
            repeat ($urandom_range(0, 4)) path_q.push_back(pick_char());
          end
        end
      end
      if ($urandom_range(0, 15) == 0) path_q.push_back(CH_SLASH);
    end
    if (path_q.size() == 0) path_q.push_back(8'h00);
  endtask

  task automatic send_random(int count);
    int stop_at;
    stop_at = bytes_sent + count;
    while (bytes_sent < stop_at) begin
      gen_path();
      send_path();
    end
  endtask

  initial begin : result_side
    int stall_left;
    stall_left = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_req = 1'b0;
      end
      if (stall_left > 0) begin
        out_tready = 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        out_tready = 1'b0;
        stall_left = $urandom_range(1, 16) - 1;
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL radix50_filename_encoder");
    $finish;
  end

  initial begin : stimulus
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = 8'h00;
    in_tlast  = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    add_text("x/a.b");
    send_path();
    add_text("Zz09 \t-_$~");
    send_path();
    add_text(".a.b.");
    send_path();
    path_q = '{8'hAE, 8'hAF, 8'hFF, 8'h00};
    send_path();
    add_text("/");
    send_path();

    send_random(RANDOM_BYTES / 2);

    // back up the encoder behind a long result-side hold
    hold_req = 1'b1;
    repeat (40) begin
      path_q.push_back(pick_char());
      send_path();
    end
    wait (!hold_req);

    send_random(RANDOM_BYTES / 4);

    // drain every result before going on
    @(negedge clk);
    in_tvalid = 1'b0;
    wait (pending == 0);

    send_random(RANDOM_BYTES / 4 - QUIET_BYTES);
    idle_on = 1'b0;
    send_random(QUIET_BYTES);

    @(negedge clk);
    in_tvalid = 1'b0;
    in_tlast  = 1'b0;
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("PASS radix50_filename_encoder");
    end else begin
      $display("FAIL radix50_filename_encoder");
    end
    $finish;
  end

endmodule
